FILE: src/ssum_pkg.sv
// Shared constants, control-word types and the sequencer program store
// for the subarray sum search block. No dependencies.
package ssum_pkg;

   localparam int MAX_LEN = 1024;
   localparam int ELEM_W  = 32;
   localparam int SUM_W   = 48;
   localparam int WANT_W  = SUM_W + 1;
   localparam int IDX_W   = $clog2(MAX_LEN + 1);
   localparam int ADDR_W  = $clog2(MAX_LEN);
   localparam int PC_W    = 4;
   localparam int CSR_AW  = 4;
   localparam int CSR_DW  = 64;

   // byte address bit that separates register 0 from anything beyond the map
   localparam int CSR_SEL_BIT = 3;

   typedef enum logic [3:0] {
      ACT_NOP,
      ACT_INIT,
      ACT_RD_BASE,
      ACT_WANT,
      ACT_BOUNDS,
      ACT_PROBE,
      ACT_NARROW,
      ACT_NEXT,
      ACT_FOUND,
      ACT_MISS
   } act_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_ZERO_TARGET,
      COND_SHORT,
      COND_LO_GE_HI,
      COND_HIT,
      COND_LAST_START
   } cond_type;

   typedef struct packed {
      act_type          act;
      cond_type         cond;
      logic [PC_W-1:0]  target;
   } ucode_type;

   localparam logic [PC_W-1:0] STEP_INIT    = PC_W'(0);
   localparam logic [PC_W-1:0] STEP_BASE    = PC_W'(1);
   localparam logic [PC_W-1:0] STEP_PROBE   = PC_W'(4);
   localparam logic [PC_W-1:0] STEP_RESOLVE = PC_W'(6);
   localparam logic [PC_W-1:0] STEP_FOUND   = PC_W'(9);
   localparam logic [PC_W-1:0] STEP_MISS    = PC_W'(10);

   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_type w;
      case (pc)
         PC_W'(0):  w = '{ACT_INIT,    COND_ZERO_TARGET, STEP_MISS};
         PC_W'(1):  w = '{ACT_RD_BASE, COND_NEVER,       STEP_INIT};
         PC_W'(2):  w = '{ACT_WANT,    COND_NEVER,       STEP_INIT};
         PC_W'(3):  w = '{ACT_BOUNDS,  COND_SHORT,       STEP_MISS};
         PC_W'(4):  w = '{ACT_PROBE,   COND_LO_GE_HI,    STEP_RESOLVE};
         PC_W'(5):  w = '{ACT_NARROW,  COND_ALWAYS,      STEP_PROBE};
         PC_W'(6):  w = '{ACT_NOP,     COND_HIT,         STEP_FOUND};
         PC_W'(7):  w = '{ACT_NEXT,    COND_LAST_START,  STEP_MISS};
         PC_W'(8):  w = '{ACT_NOP,     COND_ALWAYS,      STEP_BASE};
         PC_W'(9):  w = '{ACT_FOUND,   COND_NEVER,       STEP_INIT};
         PC_W'(10): w = '{ACT_MISS,    COND_NEVER,       STEP_INIT};
         default:   w = '{ACT_MISS,    COND_NEVER,       STEP_INIT};
      endcase
      return w;
   endfunction

endpackage

FILE: src/subarray_sum_search.sv
// Subarray sum search: streams a list into a prefix-sum RAM, then a microcoded
// sequencer binary-searches each start. Depends on ssum_pkg and ssum_ram.
// Load: one element per cycle, busy stays low until the element marked last.
// Search: one init step, then per start a base read, a wanted-sum set-up, bounds and a binary search;
// one RAM read per probe, the result strobe follows the final step, busy drops with it.
// Receiver cannot stall. Reset is synchronous; it clears control and target_sum, not the RAM.
module subarray_sum_search
   import ssum_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [ELEM_W-1:0] req_element_value,
   input  logic              req_is_last,
   output logic              rsp_valid,
   output logic              rsp_found,
   output logic [IDX_W-1:0]  rsp_start_index,
   output logic [IDX_W-1:0]  rsp_end_index,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready
);

   logic [SUM_W-1:0]  target_ff, target_in;
   logic              busy_ff, busy_in;
   logic [PC_W-1:0]   pc_ff, pc_in;
   logic [IDX_W-1:0]  count_ff, count_in;
   logic [SUM_W-1:0]  run_sum_ff, run_sum_in;
   logic [IDX_W-1:0]  i_ff, i_in;
   logic [IDX_W-1:0]  lo_ff, lo_in;
   logic [IDX_W-1:0]  hi_ff, hi_in;
   logic [IDX_W-1:0]  mid_ff, mid_in;
   logic              hit_ff, hit_in;
   logic [WANT_W-1:0] want_ff, want_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_found_ff, rsp_found_in;
   logic [IDX_W-1:0]  rsp_start_ff, rsp_start_in;
   logic [IDX_W-1:0]  rsp_end_ff, rsp_end_in;

   logic              accept;
   logic              csr_wr;
   ucode_type         uw;
   logic              cond_true;
   logic [IDX_W-1:0]  mid_calc;
   logic [SUM_W-1:0]  new_sum;
   logic              ram_we;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [SUM_W-1:0]  ram_rd_data;
   logic [WANT_W-1:0] probe_val;
   logic [IDX_W-1:0]  i_minus1, mid_minus1;

   assign accept   = start && !busy_ff;
   assign csr_wr   = psel && penable && pwrite && pready;
   assign pready   = 1'b1;
   assign prdata   = paddr[CSR_SEL_BIT] ? '0 : CSR_DW'(target_ff);
   assign uw       = ucode_rom(pc_ff);
   assign mid_calc = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign new_sum  = run_sum_ff + SUM_W'(req_element_value);
   assign ram_we   = accept && (count_ff < IDX_W'(MAX_LEN));
   assign i_minus1   = i_ff - IDX_W'(1);
   assign mid_minus1 = mid_calc - IDX_W'(1);
   assign ram_rd_addr = (uw.act == ACT_RD_BASE) ? i_minus1[ADDR_W-1:0]
                                                : mid_minus1[ADDR_W-1:0];
   assign probe_val = WANT_W'(ram_rd_data);

   ssum_ram #(.WIDTH(SUM_W), .DEPTH(MAX_LEN)) u_sums (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (new_sum),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      case (uw.cond)
         COND_NEVER:       cond_true = 1'b0;
         COND_ALWAYS:      cond_true = 1'b1;
         COND_ZERO_TARGET: cond_true = (target_ff == '0);
         COND_SHORT:       cond_true = (WANT_W'(run_sum_ff) < want_ff);
         COND_LO_GE_HI:    cond_true = (lo_ff >= hi_ff);
         COND_HIT:         cond_true = hit_ff;
         COND_LAST_START:  cond_true = ((i_ff + IDX_W'(1)) >= count_ff);
         default:          cond_true = 1'b0;
      endcase
   end

   always_comb begin
      target_in    = target_ff;
      busy_in      = busy_ff;
      pc_in        = pc_ff;
      count_in     = count_ff;
      run_sum_in   = run_sum_ff;
      i_in         = i_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      hit_in       = hit_ff;
      want_in      = want_ff;
      rsp_valid_in = 1'b0;
      rsp_found_in = rsp_found_ff;
      rsp_start_in = rsp_start_ff;
      rsp_end_in   = rsp_end_ff;

      if (csr_wr && !paddr[CSR_SEL_BIT]) begin
         target_in = pwdata[SUM_W-1:0];
      end

      if (!busy_ff) begin
         pc_in = STEP_INIT;
         if (accept) begin
            if (ram_we) begin
               run_sum_in = new_sum;
               count_in   = count_ff + IDX_W'(1);
            end
            if (req_is_last) begin
               busy_in = 1'b1;
            end
         end
      end else begin
         pc_in = cond_true ? uw.target : pc_ff + PC_W'(1);
         case (uw.act)
            ACT_INIT: begin
               i_in = '0;
            end
            ACT_WANT: begin
               want_in = ((i_ff == '0) ? '0 : probe_val) + WANT_W'(target_ff);
            end
            ACT_BOUNDS: begin
               lo_in  = i_ff + IDX_W'(1);
               hi_in  = count_ff + IDX_W'(1);
               hit_in = 1'b0;
            end
            ACT_PROBE: begin
               mid_in = mid_calc;
            end
            ACT_NARROW: begin
               if (probe_val < want_ff) begin
                  lo_in = mid_ff + IDX_W'(1);
               end else begin
                  hi_in  = mid_ff;
                  hit_in = (probe_val == want_ff);
               end
            end
            ACT_NEXT: begin
               i_in = i_ff + IDX_W'(1);
            end
            ACT_FOUND: begin
               busy_in      = 1'b0;
               rsp_valid_in = 1'b1;
               rsp_found_in = 1'b1;
               rsp_start_in = i_ff + IDX_W'(1);
               rsp_end_in   = lo_ff;
               count_in     = '0;
               run_sum_in   = '0;
            end
            ACT_MISS: begin
               busy_in      = 1'b0;
               rsp_valid_in = 1'b1;
               rsp_found_in = 1'b0;
               rsp_start_in = '0;
               rsp_end_in   = '0;
               count_in     = '0;
               run_sum_in   = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff    <= '0;
         busy_ff      <= 1'b0;
         pc_ff        <= STEP_INIT;
         count_ff     <= '0;
         run_sum_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         target_ff    <= target_in;
         busy_ff      <= busy_in;
         pc_ff        <= pc_in;
         count_ff     <= count_in;
         run_sum_ff   <= run_sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff         <= i_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      hit_ff       <= hit_in;
      want_ff      <= want_in;
      rsp_found_ff <= rsp_found_in;
      rsp_start_ff <= rsp_start_in;
      rsp_end_ff   <= rsp_end_in;
   end

   assign busy            = busy_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_start_index = rsp_start_ff;
   assign rsp_end_index   = rsp_end_ff;

   a_rsp_after_search: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(busy_ff) && !busy_ff))
      else $error("result without a finished search");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff) |-> (rsp_start_ff == '0 && rsp_end_ff == '0))
      else $error("not-found result carries indexes");

   a_found_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_found_ff) |->
         (rsp_start_ff != '0 && rsp_start_ff <= rsp_end_ff
          && rsp_end_ff <= IDX_W'(MAX_LEN)))
      else $error("found run has bad bounds");

   a_no_load_in_search: assert property (@(posedge clock) disable iff (reset)
      busy_ff |=> ($stable(count_ff) || count_ff == '0))
      else $error("element count moved during search");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= IDX_W'(MAX_LEN))
      else $error("element count beyond list capacity");

endmodule

FILE: src/ssum_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ssum_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
